// ===== hdl/pssw_pkg.sv =====
// Shared constants, types and the spacing table of the per-source sliding window limiter.
package pssw_pkg;

    localparam int NUM_SOURCES    = 64;
    localparam int MAX_LIMIT      = 16;
    localparam int SRC_W          = $clog2(NUM_SOURCES);
    localparam int POS_W          = $clog2(MAX_LIMIT);
    localparam int CNT_W          = $clog2(MAX_LIMIT + 1);
    localparam int SLOT_W         = SRC_W + POS_W;
    localparam int TIME_W         = 32;
    localparam int SPACING_W      = 12;
    localparam int LIMIT_W        = 5;
    localparam int CASE_W         = 3;

    localparam logic [TIME_W-1:0] WINDOW_SECONDS = TIME_W'(3600);

    localparam logic [CASE_W-1:0] CASE_UNLIMITED = 3'd0;
    localparam logic [CASE_W-1:0] CASE_FIRST     = 3'd1;
    localparam logic [CASE_W-1:0] CASE_SPACED    = 3'd2;
    localparam logic [CASE_W-1:0] CASE_TOO_SOON  = 3'd3;
    localparam logic [CASE_W-1:0] CASE_SLID      = 3'd4;
    localparam logic [CASE_W-1:0] CASE_FULL      = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_META,
        ST_TIME
    } state_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [POS_W-1:0] head;
    } meta_t;

    typedef struct packed {
        logic             en;
        logic [SRC_W-1:0] addr;
    } meta_rd_t;

    typedef struct packed {
        logic             en;
        logic [SRC_W-1:0] addr;
        meta_t            data;
    } meta_wr_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
    } time_rd_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        logic [TIME_W-1:0] data;
    } time_wr_t;

    // Minimum spacing 3600 / limit, truncated; limits are already clamped.
    function automatic logic [SPACING_W-1:0] spacing_of(input logic [LIMIT_W-1:0] lim);
        logic [SPACING_W-1:0] s;
        case (lim)
            5'd1:    s = 12'd3600;
            5'd2:    s = 12'd1800;
            5'd3:    s = 12'd1200;
            5'd4:    s = 12'd900;
            5'd5:    s = 12'd720;
            5'd6:    s = 12'd600;
            5'd7:    s = 12'd514;
            5'd8:    s = 12'd450;
            5'd9:    s = 12'd400;
            5'd10:   s = 12'd360;
            5'd11:   s = 12'd327;
            5'd12:   s = 12'd300;
            5'd13:   s = 12'd276;
            5'd14:   s = 12'd257;
            5'd15:   s = 12'd240;
            5'd16:   s = 12'd225;
            default: s = '0;
        endcase
        return s;
    endfunction

endpackage

// ===== hdl/pssw_meta_store.sv =====
// Per-source count and head memory with valid bits that reset clears.
module pssw_meta_store (
    input  logic               clk,
    input  logic               rst_n,
    input  pssw_pkg::meta_rd_t rd,
    input  pssw_pkg::meta_wr_t wr,
    output pssw_pkg::meta_t    rd_data
);
    import pssw_pkg::*;

    meta_t                  mem [NUM_SOURCES];
    logic [NUM_SOURCES-1:0] valid_reg;
    meta_t                  rd_data_reg;
    logic                   rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd.en)
            begin
                rd_valid_reg <= valid_reg[rd.addr];
            end
        end
    end

    // An entry never written reads as an empty log.
    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ===== hdl/pssw_time_store.sv =====
// Grant time memory, one ring of entries per source.
module pssw_time_store (
    input  logic                        clk,
    input  pssw_pkg::time_rd_t          rd,
    input  pssw_pkg::time_wr_t          wr,
    output logic [pssw_pkg::TIME_W-1:0] rd_data
);
    import pssw_pkg::*;

    localparam int DEPTH = NUM_SOURCES * MAX_LIMIT;

    logic [TIME_W-1:0] mem [DEPTH];
    logic [TIME_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/pssw_ctrl.sv =====
// Request sequencer: reads the log state, decides, writes back and holds the result.
module pssw_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [pssw_pkg::SRC_W-1:0]     source_index,
    input  logic [pssw_pkg::TIME_W-1:0]    now_seconds,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pssw_pkg::LIMIT_W-1:0]   cfg_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           allowed,
    output logic [pssw_pkg::CASE_W-1:0]    decision_case,
    output pssw_pkg::meta_rd_t             meta_rd,
    output pssw_pkg::meta_wr_t             meta_wr,
    input  pssw_pkg::meta_t                meta_data,
    output pssw_pkg::time_rd_t             time_rd,
    output pssw_pkg::time_wr_t             time_wr,
    input  logic [pssw_pkg::TIME_W-1:0]    time_data
);
    import pssw_pkg::*;

    state_t                state_reg, state_next;
    logic [LIMIT_W-1:0]    limit_reg;
    logic [SPACING_W-1:0]  spacing_reg;
    logic [LIMIT_W-1:0]    limit_clamped;
    logic [SRC_W-1:0]      src_reg;
    logic [TIME_W-1:0]     now_reg;
    logic                  out_valid_reg, out_valid_next;
    logic                  allowed_reg, allowed_next;
    logic [CASE_W-1:0]     case_reg, case_next;
    logic                  accept;
    logic                  finish;
    logic                  in_spacing;
    logic [POS_W-1:0]      read_pos;
    logic [TIME_W-1:0]     diff;
    logic [POS_W-1:0]      append_pos;

    assign cfg_ready     = 1'b1;
    assign limit_clamped = (cfg_data > LIMIT_W'(MAX_LIMIT)) ? LIMIT_W'(MAX_LIMIT) : cfg_data;

    assign accept     = in_valid && in_ready;
    assign finish     = (state_reg == ST_TIME) && (!out_valid_reg || out_ready);
    assign in_spacing = (meta_data.count != '0) &&
                        (meta_data.count < CNT_W'(limit_reg));
    assign read_pos   = in_spacing ? (meta_data.head + meta_data.count[POS_W-1:0] - POS_W'(1))
                                   : meta_data.head;
    assign append_pos = meta_data.head + meta_data.count[POS_W-1:0];
    assign diff       = now_reg - time_data;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_META;
            ST_META: state_next = ST_TIME;
            ST_TIME: if (finish) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready      = (state_reg == ST_IDLE);
        meta_rd.en    = accept;
        meta_rd.addr  = source_index;
        time_rd.en    = (state_reg == ST_META);
        time_rd.addr  = {src_reg, read_pos};
        meta_wr.en    = 1'b0;
        meta_wr.addr  = src_reg;
        meta_wr.data  = meta_data;
        time_wr.en    = 1'b0;
        time_wr.addr  = {src_reg, append_pos};
        time_wr.data  = now_reg;
        allowed_next  = allowed_reg;
        case_next     = case_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (finish)
        begin
            out_valid_next = 1'b1;
            allowed_next   = 1'b0;
            if (limit_reg == '0)
            begin
                allowed_next = 1'b1;
                case_next    = CASE_UNLIMITED;
            end
            else if (meta_data.count == '0)
            begin
                allowed_next        = 1'b1;
                case_next           = CASE_FIRST;
                time_wr.en          = 1'b1;
                time_wr.addr        = {src_reg, meta_data.head};
                meta_wr.en          = 1'b1;
                meta_wr.data.count  = CNT_W'(1);
            end
            else if (in_spacing)
            begin
                if (diff >= TIME_W'(spacing_reg))
                begin
                    allowed_next       = 1'b1;
                    case_next          = CASE_SPACED;
                    time_wr.en         = 1'b1;
                    meta_wr.en         = 1'b1;
                    meta_wr.data.count = meta_data.count + CNT_W'(1);
                end
                else
                begin
                    case_next = CASE_TOO_SOON;
                end
            end
            else
            begin
                if (diff > WINDOW_SECONDS)
                begin
                    allowed_next      = 1'b1;
                    case_next         = CASE_SLID;
                    time_wr.en        = 1'b1;
                    meta_wr.en        = 1'b1;
                    meta_wr.data.head = meta_data.head + POS_W'(1);
                end
                else
                begin
                    case_next = CASE_FULL;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            limit_reg     <= '0;
            spacing_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                limit_reg   <= limit_clamped;
                spacing_reg <= spacing_of(limit_clamped);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            src_reg <= source_index;
            now_reg <= now_seconds;
        end
        allowed_reg <= allowed_next;
        case_reg    <= case_next;
    end

    assign out_valid     = out_valid_reg;
    assign allowed       = allowed_reg;
    assign decision_case = case_reg;

endmodule

// ===== hdl/per_source_sliding_window_limiter.sv =====
// Top level of the per-source sliding window rate limiter.
//
// Each request item names a source and carries the current time in seconds;
// one result item comes back per request, saying allow or deny and which rule
// decided. Every source keeps a ring of up to sixteen grant times. With a
// limit of 0 everything is allowed. Below the limit, a grant needs the
// spacing 3600 / limit (worked out when the limit is written) since the
// newest grant; at the limit, the oldest entry must be more than 3600 seconds
// old, and is then replaced. Time differences wrap modulo 2^32. On
// acceptance of an item the count and head of the source are read, then the
// grant time that they point at, and then the decision writes both memories
// back and loads the output register. The sequencer takes no new item until
// it has decided and is back in idle; the next item may be taken while the
// result still waits in the output register, and it then holds in its
// decide cycle until that result is taken. Count and head come out of reset
// empty through per-source valid bits, so there is no clearing pass. Write
// the limit only while idle; values above 16 clamp to 16.
module per_source_sliding_window_limiter (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [39:0]                  s_tdata,   // [5:0] source_index, [37:6] now_seconds
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [7:0]                   m_tdata,   // [0] allowed, [3:1] decision_case
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [pssw_pkg::LIMIT_W-1:0] cfg_data   // grant_limit
);
    import pssw_pkg::*;

    meta_rd_t          meta_rd;
    meta_wr_t          meta_wr;
    meta_t             meta_data;
    time_rd_t          time_rd;
    time_wr_t          time_wr;
    logic [TIME_W-1:0] time_data;
    logic              allowed;
    logic [CASE_W-1:0] decision_case;

    // Sequencer: holds the request, reads both stores, decides and writes back.
    pssw_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .source_index  (s_tdata[SRC_W-1:0]),
        .now_seconds   (s_tdata[SRC_W +: TIME_W]),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .allowed       (allowed),
        .decision_case (decision_case),
        .meta_rd       (meta_rd),
        .meta_wr       (meta_wr),
        .meta_data     (meta_data),
        .time_rd       (time_rd),
        .time_wr       (time_wr),
        .time_data     (time_data)
    );

    // Count and head of each source's log.
    pssw_meta_store u_meta (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd      (meta_rd),
        .wr      (meta_wr),
        .rd_data (meta_data)
    );

    // Logged grant times, addressed by source and ring position.
    pssw_time_store u_time (
        .clk     (clk),
        .rd      (time_rd),
        .wr      (time_wr),
        .rd_data (time_data)
    );

    // Pack the result: allowed in the lowest bit, then the decision code.
    assign m_tdata = {4'b0000, decision_case, allowed};

endmodule
